// ===== hw/rtl/fbpa_pkg.sv =====
package fbpa_pkg;

  // Pool geometry. Slot fields are 8 bits, so the usable pool stops at 256.
  localparam int SLOTS      = 256;
  localparam int SLOT_W     = 8;
  localparam int CNT_W      = 9;
  localparam int SLOT_REACH = 256;
  localparam int SLOT_LIMIT = (SLOTS < SLOT_REACH) ? SLOTS : SLOT_REACH;

  // Request kinds
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  // Result status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_EMPTY   = 2'd1;
  localparam logic [1:0] STS_RANGE   = 2'd2;
  localparam logic [1:0] STS_NOT_USE = 2'd3;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // capture request, launch stack and flag reads
    logic exec;   // apply request, load result register
    logic wipe;   // sweep one slot: stack entry = index, flag cleared
  } fbpa_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_blocked;  // result register full and stalled
    logic is_init;      // captured request is a reinitialize
    logic wipe_last;    // sweep is at the last slot
  } fbpa_sts_t;

endpackage

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+-------------------------------------
// request  | in_valid_i/in_stall_o   | kind_i[1:0], slot_in_i[7:0]
// result   | out_valid_o/out_stall_i | slot_out_o[7:0], status_o[1:0],
//          |                         | free_left_o[8:0]
// config   | cfg_we_i                | cfg_wdata_i[8:0] (slot_count)
//
// Allocate, free and the unused kind first capture the request and read the
// stack and in-use flag (registered RAM reads), then apply it and load the
// result register. Reinitialize goes through capture, decode, a sweep that
// rewrites every stack entry and clears every flag, then apply.
// Reset (rst_ni, async low) starts the same sweep with the input stalled;
// afterwards the pool holds all 256 slots. A new request is taken while the
// previous result still waits; its apply cycle holds off until the result
// register frees up.
module fixed_block_pool_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                kind_i,
  input  logic [fbpa_pkg::SLOT_W-1:0] slot_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [fbpa_pkg::SLOT_W-1:0] slot_out_o,
  output logic [1:0]                status_o,
  output logic [fbpa_pkg::CNT_W-1:0] free_left_o,
  input  logic                      cfg_we_i,
  input  logic [fbpa_pkg::CNT_W-1:0] cfg_wdata_i
);
  import fbpa_pkg::*;

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;

  // Sequencer: boot sweep -> idle -> exec (-> init sweep -> apply) -> idle
  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stack RAM, in-use flag RAM, free count, result register
  fbpa_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (kind_i),
    .slot_in_i   (slot_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .slot_out_o  (slot_out_o),
    .status_o    (status_o),
    .free_left_o (free_left_o)
  );

endmodule

// ===== hw/rtl/fbpa_ctrl.sv =====
module fbpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fbpa_pkg::fbpa_sts_t sts_i,
  output fbpa_pkg::fbpa_cmd_t cmd_o
);
  import fbpa_pkg::*;

  localparam logic [2:0] ST_BOOT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_WIPE  = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    cmd_o.wipe = 1'b0;
    unique case (state_q)
      ST_BOOT: begin
        cmd_o.wipe = 1'b1;
        if (sts_i.wipe_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_init) begin
          state_d = ST_WIPE;
        end else if (!sts_i.out_blocked) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_WIPE: begin
        cmd_o.wipe = 1'b1;
        if (sts_i.wipe_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!sts_i.out_blocked) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_BOOT;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/fbpa_dpath.sv =====
module fbpa_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fbpa_pkg::fbpa_cmd_t       cmd_i,
  output fbpa_pkg::fbpa_sts_t       sts_o,
  input  logic [1:0]                kind_i,
  input  logic [fbpa_pkg::SLOT_W-1:0] slot_in_i,
  input  logic                      cfg_we_i,
  input  logic [fbpa_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [fbpa_pkg::SLOT_W-1:0] slot_out_o,
  output logic [1:0]                status_o,
  output logic [fbpa_pkg::CNT_W-1:0] free_left_o
);
  import fbpa_pkg::*;

  // Free stack and in-use flags; both are swept after reset and on reinitialize.
  logic [SLOT_W-1:0] stack_mem  [SLOTS];
  logic              in_use_mem [SLOTS];
  logic [CNT_W-1:0]  fc_q, fc_d;
  logic [CNT_W-1:0]  slot_count_q;
  logic [CNT_W-1:0]  eff_slots;
  logic [SLOT_W-1:0] wipe_addr_q;

  logic [1:0]        kind_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] rd_addr, rd_data_q;
  logic              use_rd_q;

  logic              stk_we;
  logic [SLOT_W-1:0] stk_waddr;
  logic [SLOT_W-1:0] stk_wdata;
  logic              use_we;
  logic [SLOT_W-1:0] use_waddr;
  logic              use_wdata;
  logic [SLOT_W-1:0] granted;
  logic [1:0]        stat;

  logic              out_valid_q;
  logic [SLOT_W-1:0] slot_out_q;
  logic [1:0]        status_q;
  logic [CNT_W-1:0]  free_left_q;

  assign eff_slots = (slot_count_q > CNT_W'(SLOT_LIMIT)) ? CNT_W'(SLOT_LIMIT) : slot_count_q;
  assign rd_addr   = SLOT_W'(fc_q - CNT_W'(1));
  assign stk_waddr = cmd_i.wipe ? wipe_addr_q : fc_q[SLOT_W-1:0];
  assign stk_wdata = cmd_i.wipe ? wipe_addr_q : slot_q;

  always_comb begin
    fc_d      = fc_q;
    stk_we    = 1'b0;
    use_we    = 1'b0;
    use_waddr = slot_q;
    use_wdata = 1'b0;
    granted   = '0;
    stat      = STS_OK;
    if (cmd_i.exec) begin
      case (kind_q)
        KIND_ALLOC: begin
          if (fc_q == '0 || fc_q > CNT_W'(SLOTS)) begin
            stat = STS_EMPTY;
          end else begin
            fc_d      = fc_q - CNT_W'(1);
            use_we    = 1'b1;
            use_waddr = rd_data_q;
            use_wdata = 1'b1;
            granted   = rd_data_q;
          end
        end
        KIND_FREE: begin
          if ({1'b0, slot_q} >= eff_slots) begin
            stat = STS_RANGE;
          end else if (!use_rd_q) begin
            stat = STS_NOT_USE;
          end else begin
            use_we    = 1'b1;
            use_waddr = slot_q;
            use_wdata = 1'b0;
            if (fc_q < CNT_W'(SLOTS)) begin
              stk_we = 1'b1;
              fc_d   = fc_q + CNT_W'(1);
            end
          end
        end
        KIND_INIT: begin
          fc_d = eff_slots;
        end
        default: ;  // unused kind: no change
      endcase
    end
    if (cmd_i.wipe) begin
      stk_we    = 1'b1;
      use_we    = 1'b1;
      use_waddr = wipe_addr_q;
      use_wdata = 1'b0;
    end
  end

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
  end

  // In-use flags: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (use_we) begin
      in_use_mem[use_waddr] <= use_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_data_q <= stack_mem[rd_addr];
      use_rd_q  <= in_use_mem[slot_in_i];
      kind_q    <= kind_i;
      slot_q    <= slot_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_addr_q  <= '0;
      fc_q         <= CNT_W'(SLOT_LIMIT);
      slot_count_q <= CNT_W'(SLOT_REACH);
      out_valid_q  <= 1'b0;
    end else begin
      fc_q <= fc_d;
      if (cmd_i.wipe) begin
        wipe_addr_q <= wipe_addr_q + SLOT_W'(1);
      end
      if (cfg_we_i) begin
        slot_count_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      slot_out_q  <= granted;
      status_q    <= stat;
      free_left_q <= fc_d;
    end
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;
  assign sts_o.is_init     = (kind_q == KIND_INIT);
  assign sts_o.wipe_last   = (wipe_addr_q == SLOT_W'(SLOTS - 1));
  assign out_valid_o = out_valid_q;
  assign slot_out_o  = slot_out_q;
  assign status_o    = status_q;
  assign free_left_o = free_left_q;

endmodule

// ===== hw/rtl/fbpa_checker.sv =====
module fbpa_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [fbpa_pkg::SLOT_W-1:0] slot_out_o,
  input logic [1:0]                status_o,
  input logic [fbpa_pkg::CNT_W-1:0] free_left_o
);
  import fbpa_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_out_o)
      && $stable(status_o) && $stable(free_left_o))
    else $error("stalled result changed");

  // One request in flight: accept is followed by stall
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // Granted slot only with ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_out_o != '0 |-> status_o == STS_OK)
    else $error("slot granted with error status");

  // Empty pool reports zero free
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STS_EMPTY |-> free_left_o == '0)
    else $error("empty status with free slots");

  // Free count never exceeds pool size
  a_fc_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_left_o <= CNT_W'(SLOT_LIMIT))
    else $error("free count above pool size");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
